// ----- rtl/dat_pkg.sv -----
// Package for the device address table: field widths, status codes, the stored
// entry layout, controller states and the command/status bundles between the
// controller and the datapath. Depends on nothing.
package dat_pkg;

  // Field widths of the transaction payloads.
  localparam int ID_W       = 22;
  localparam int APDU_W     = 16;
  localparam int NET_W      = 16;
  localparam int LEN_W      = 3;
  localparam int BYTES_W    = 48;
  localparam int RIDX_W     = 6;
  localparam int EIDX_W     = 6;
  localparam int ECNT_W     = 7;
  localparam int STATUS_W   = 3;

  // Number of address bytes that take part in the address comparison.
  localparam int ADDR_BYTES = 6;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED      = 3'd0,
    STATUS_PRESENT    = 3'd1,
    STATUS_FULL       = 3'd2,
    STATUS_READ_OK    = 3'd3,
    STATUS_READ_EMPTY = 3'd4
  } status_t;

  // One stored table entry, without its multiple flag.
  typedef struct packed {
    logic [ID_W-1:0]    dev_id;
    logic [APDU_W-1:0]  apdu;
    logic [NET_W-1:0]   net;
    logic [LEN_W-1:0]   alen;
    logic [BYTES_W-1:0] addr;
    logic [LEN_W-1:0]   mlen;
    logic [BYTES_W-1:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_READ,
    CS_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan;
    logic read_issue;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_is_read;
    logic scan_found;
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // Byte mask of the address bytes that are compared for a given length.
  function automatic logic [BYTES_W-1:0] addr_mask(input logic [LEN_W-1:0] len);
    logic [BYTES_W-1:0] m;
    m = '0;
    for (int b = 0; b < BYTES_W / 8; b++) begin
      if ((b < int'(len)) && (b < ADDR_BYTES)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/dat_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dat_ctrl.sv -----
// Controller state machine of the device address table.
// Depends on dat_pkg for the state type and the command/status bundles.
module dat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dat_pkg::dp_status_t status,
  output dat_pkg::dp_cmd_t    cmd
);

  dat_pkg::ctrl_state_t state_r;
  dat_pkg::ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dat_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dat_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_nxt = status.new_is_read ? dat_pkg::CS_READ : dat_pkg::CS_SCAN;
        end
      end
      dat_pkg::CS_SCAN: begin
        if (status.scan_found || status.scan_end) begin
          state_nxt = dat_pkg::CS_DONE;
        end
      end
      dat_pkg::CS_READ: begin
        state_nxt = dat_pkg::CS_DONE;
      end
      dat_pkg::CS_DONE: begin
        if (status.out_free) begin
          state_nxt = dat_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = dat_pkg::CS_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state. No transaction is taken while in reset.
  always_comb begin
    in_ready       = 1'b0;
    cmd.load_req   = 1'b0;
    cmd.scan       = 1'b0;
    cmd.read_issue = 1'b0;
    cmd.finish     = 1'b0;
    case (state_r)
      dat_pkg::CS_IDLE: begin
        in_ready     = rst_n;
        cmd.load_req = in_valid && rst_n;
      end
      dat_pkg::CS_SCAN: begin
        cmd.scan = 1'b1;
      end
      dat_pkg::CS_READ: begin
        cmd.read_issue = 1'b1;
      end
      dat_pkg::CS_DONE: begin
        cmd.finish = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/dat_datapath.sv -----
// Datapath of the device address table: request registers, fill count, the
// entry and flag memories, the scan compare pipeline and the result register.
// Depends on dat_pkg and dat_ram.
module dat_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dat_pkg::dp_cmd_t                  cmd,
  output dat_pkg::dp_status_t               status,
  input  logic                              in_operation,
  input  logic [dat_pkg::ID_W-1:0]          in_device_id,
  input  logic [dat_pkg::APDU_W-1:0]        in_max_apdu,
  input  logic [dat_pkg::NET_W-1:0]         in_net_number,
  input  logic [dat_pkg::LEN_W-1:0]         in_addr_len,
  input  logic [dat_pkg::BYTES_W-1:0]       in_addr_bytes,
  input  logic [dat_pkg::LEN_W-1:0]         in_mac_len,
  input  logic [dat_pkg::BYTES_W-1:0]       in_mac_bytes,
  input  logic [dat_pkg::RIDX_W-1:0]        in_read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dat_pkg::STATUS_W-1:0]      out_status,
  output logic [dat_pkg::EIDX_W-1:0]        out_entry_index,
  output logic                              out_multiple_flag,
  output logic [dat_pkg::ID_W-1:0]          out_entry_device_id,
  output logic [dat_pkg::APDU_W-1:0]        out_entry_max_apdu,
  output logic [dat_pkg::NET_W-1:0]         out_entry_net,
  output logic [dat_pkg::LEN_W-1:0]         out_entry_addr_len,
  output logic [dat_pkg::BYTES_W-1:0]       out_entry_addr_bytes,
  output logic [dat_pkg::LEN_W-1:0]         out_entry_mac_len,
  output logic [dat_pkg::BYTES_W-1:0]       out_entry_mac_bytes,
  output logic [dat_pkg::ECNT_W-1:0]        out_entry_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > dat_pkg::RIDX_W) ? CNT_W : dat_pkg::RIDX_W;
  localparam int ENT_W = $bits(dat_pkg::entry_t);

  // Request registers.
  dat_pkg::op_t                   req_op_r;
  logic [dat_pkg::ID_W-1:0]       req_id_r;
  logic [dat_pkg::APDU_W-1:0]     req_apdu_r;
  logic [dat_pkg::NET_W-1:0]      req_net_r;
  logic [dat_pkg::LEN_W-1:0]      req_alen_r;
  logic [dat_pkg::BYTES_W-1:0]    req_addr_r;
  logic [dat_pkg::LEN_W-1:0]      req_mlen_r;
  logic [dat_pkg::BYTES_W-1:0]    req_mac_r;
  logic [dat_pkg::RIDX_W-1:0]     req_ridx_r;

  // Table and scan state.
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r;
  logic             multi_acc_r, multi_acc_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] match_idx_r;
  logic             match_multi_r;

  // Memory ports.
  dat_pkg::entry_t  rd_entry;
  dat_pkg::entry_t  wr_entry;
  logic             rd_multi;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             multi_we;
  logic [IDX_W-1:0] multi_waddr;
  logic             multi_wdata;

  // Compare and control signals.
  logic                        issue;
  logic                        more_to_issue;
  logic                        read_in_range;
  logic                        check;
  logic                        id_eq;
  logic                        addr_eq;
  logic                        hit;
  logic                        alias_hit;
  logic [dat_pkg::BYTES_W-1:0] amask;
  logic                        full;
  logic                        load;
  logic                        append;
  logic [CNT_W-1:0]            fill_inc;

  // Result and output register.
  logic                        out_valid_r, out_valid_nxt;
  dat_pkg::status_t            res_status, out_status_r;
  logic [dat_pkg::EIDX_W-1:0]  res_index, out_index_r;
  logic                        res_multi, out_multi_r;
  dat_pkg::entry_t             res_entry, out_entry_r;
  logic [dat_pkg::ECNT_W-1:0]  res_count, out_count_r;

  // Latch the request payload on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r   <= dat_pkg::op_t'(in_operation);
      req_id_r   <= in_device_id;
      req_apdu_r <= in_max_apdu;
      req_net_r  <= in_net_number;
      req_alen_r <= in_addr_len;
      req_addr_r <= in_addr_bytes;
      req_mlen_r <= in_mac_len;
      req_mac_r  <= in_mac_bytes;
      req_ridx_r <= in_read_index;
    end
  end

  // Read address selection: the scan walks the table, a read uses its index.
  assign more_to_issue = issue_idx_r < fill_cnt_r;
  assign issue         = cmd.scan && more_to_issue;
  assign read_in_range = CMP_W'(req_ridx_r) < CMP_W'(fill_cnt_r);
  assign rd_en         = issue || (cmd.read_issue && read_in_range);
  assign rd_addr       = cmd.scan ? issue_idx_r[IDX_W-1:0] : IDX_W'(req_ridx_r);

  // Compare the entry returned by the memory with the request.
  assign amask   = dat_pkg::addr_mask(req_alen_r);
  assign check   = cmd.scan && chk_vld_r;
  assign id_eq   = rd_entry.dev_id == req_id_r;
  assign addr_eq = (rd_entry.net == req_net_r) && (rd_entry.alen == req_alen_r) &&
                   (((rd_entry.addr ^ req_addr_r) & amask) == '0);
  assign hit       = check && id_eq && addr_eq;
  assign alias_hit = check && id_eq && !addr_eq;

  // Completion: load the result, and append an add when no equal entry was found and the table is not full.
  assign full     = fill_cnt_r == CNT_W'(TABLE_DEPTH);
  assign load     = cmd.finish && (!out_valid_r || out_ready);
  assign append   = load && (req_op_r == dat_pkg::OP_ADD) && !found_r && !full;
  assign fill_inc = fill_cnt_r + CNT_W'(1);

  // Scan bookkeeping and fill count.
  always_comb begin
    fill_cnt_nxt  = append ? fill_inc : fill_cnt_r;
    issue_idx_nxt = issue_idx_r;
    chk_vld_nxt   = 1'b0;
    multi_acc_nxt = multi_acc_r;
    found_nxt     = found_r;
    if (cmd.load_req) begin
      issue_idx_nxt = '0;
      multi_acc_nxt = 1'b0;
      found_nxt     = 1'b0;
    end else if (cmd.scan) begin
      issue_idx_nxt = issue ? issue_idx_r + CNT_W'(1) : issue_idx_r;
      chk_vld_nxt   = issue;
      multi_acc_nxt = multi_acc_r || alias_hit;
      found_nxt     = found_r || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      issue_idx_r <= '0;
      chk_vld_r   <= 1'b0;
      multi_acc_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      fill_cnt_r  <= fill_cnt_nxt;
      issue_idx_r <= issue_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      multi_acc_r <= multi_acc_nxt;
      found_r     <= found_nxt;
    end
  end

  // Index of the entry in the compare stage and of the equal entry.
  always_ff @(posedge clk) begin
    chk_idx_r <= issue_idx_r[IDX_W-1:0];
    if (hit) begin
      match_idx_r   <= chk_idx_r;
      match_multi_r <= rd_multi;
    end
  end

  // Entry memory: written on append.
  always_comb begin
    wr_entry.dev_id = req_id_r;
    wr_entry.apdu   = req_apdu_r;
    wr_entry.net    = req_net_r;
    wr_entry.alen   = req_alen_r;
    wr_entry.addr   = req_addr_r;
    wr_entry.mlen   = req_mlen_r;
    wr_entry.mac    = req_mac_r;
  end

  dat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (append),
    .waddr (fill_cnt_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // Multiple-flag memory: set during the scan, initialized on append.
  assign multi_we    = append || alias_hit;
  assign multi_waddr = alias_hit ? chk_idx_r : fill_cnt_r[IDX_W-1:0];
  assign multi_wdata = alias_hit || multi_acc_r;

  dat_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_multi_ram (
    .clk   (clk),
    .we    (multi_we),
    .waddr (multi_waddr),
    .wdata (multi_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_multi)
  );

  // Result selection.
  always_comb begin
    res_status = dat_pkg::STATUS_ADDED;
    res_index  = '0;
    res_multi  = 1'b0;
    res_entry  = '0;
    res_count  = dat_pkg::ECNT_W'(append ? fill_inc : fill_cnt_r);
    if (req_op_r == dat_pkg::OP_READ) begin
      res_index = req_ridx_r;
      if (read_in_range) begin
        res_status = dat_pkg::STATUS_READ_OK;
        res_multi  = rd_multi;
        res_entry  = rd_entry;
      end else begin
        res_status = dat_pkg::STATUS_READ_EMPTY;
      end
    end else if (found_r) begin
      res_status = dat_pkg::STATUS_PRESENT;
      res_index  = dat_pkg::EIDX_W'(match_idx_r);
      res_multi  = match_multi_r;
    end else if (full) begin
      res_status = dat_pkg::STATUS_FULL;
      res_multi  = multi_acc_r;
    end else begin
      res_index  = dat_pkg::EIDX_W'(fill_cnt_r);
      res_multi  = multi_acc_r;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_multi_r  <= res_multi;
      out_entry_r  <= res_entry;
      out_count_r  <= res_count;
    end
  end

  // Status back to the controller.
  assign status.new_is_read = in_operation == dat_pkg::OP_READ;
  assign status.scan_found  = hit;
  assign status.scan_end    = cmd.scan && !chk_vld_r && !more_to_issue;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_entry_index      = out_index_r;
  assign out_multiple_flag    = out_multi_r;
  assign out_entry_device_id  = out_entry_r.dev_id;
  assign out_entry_max_apdu   = out_entry_r.apdu;
  assign out_entry_net        = out_entry_r.net;
  assign out_entry_addr_len   = out_entry_r.alen;
  assign out_entry_addr_bytes = out_entry_r.addr;
  assign out_entry_mac_len    = out_entry_r.mlen;
  assign out_entry_mac_bytes  = out_entry_r.mac;
  assign out_entry_count      = out_count_r;

endmodule

// ----- rtl/device_address_table_top.sv -----
// Top level of the device address table: controller plus datapath.
// Depends on dat_pkg, dat_ctrl and dat_datapath.
//
// The block keeps an append-only table of discovered devices. Each input
// transaction is either an add or a read; each produces exactly one result
// transaction on the out_ channel. An add scans the stored entries in index
// order, one entry per cycle through the registered read port of the entry
// memory: an entry with the same device id and an equal address ends the
// scan, entries with the same id and another address get their multiple flag
// set, and if nothing equal is found the new entry is appended (or dropped
// with status table full when all TABLE_DEPTH entries are used).
// Sequence: an add passes from the idle state through the scan state, a
// read through the read state; both end in the done state, which loads the
// result into the output register. One transaction is in work at a time
// and in_ready returns the cycle after the result is loaded. Reset clears
// the fill count and control state; the table is not cleared, and only
// entries below the fill count are read.
// A stalled receiver holds the result in the output register; the next
// transaction is still accepted and waits at completion until it is free.
module device_address_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [dat_pkg::ID_W-1:0]      in_device_id,
  input  logic [dat_pkg::APDU_W-1:0]    in_max_apdu,
  input  logic [dat_pkg::NET_W-1:0]     in_net_number,
  input  logic [dat_pkg::LEN_W-1:0]     in_addr_len,
  input  logic [dat_pkg::BYTES_W-1:0]   in_addr_bytes,
  input  logic [dat_pkg::LEN_W-1:0]     in_mac_len,
  input  logic [dat_pkg::BYTES_W-1:0]   in_mac_bytes,
  input  logic [dat_pkg::RIDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dat_pkg::STATUS_W-1:0]  out_status,
  output logic [dat_pkg::EIDX_W-1:0]    out_entry_index,
  output logic                          out_multiple_flag,
  output logic [dat_pkg::ID_W-1:0]      out_entry_device_id,
  output logic [dat_pkg::APDU_W-1:0]    out_entry_max_apdu,
  output logic [dat_pkg::NET_W-1:0]     out_entry_net,
  output logic [dat_pkg::LEN_W-1:0]     out_entry_addr_len,
  output logic [dat_pkg::BYTES_W-1:0]   out_entry_addr_bytes,
  output logic [dat_pkg::LEN_W-1:0]     out_entry_mac_len,
  output logic [dat_pkg::BYTES_W-1:0]   out_entry_mac_bytes,
  output logic [dat_pkg::ECNT_W-1:0]    out_entry_count
);

  dat_pkg::dp_cmd_t    cmd;
  dat_pkg::dp_status_t status;

  // Sequencing of each transaction.
  dat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, compare and result register.
  dat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_operation         (in_operation),
    .in_device_id         (in_device_id),
    .in_max_apdu          (in_max_apdu),
    .in_net_number        (in_net_number),
    .in_addr_len          (in_addr_len),
    .in_addr_bytes        (in_addr_bytes),
    .in_mac_len           (in_mac_len),
    .in_mac_bytes         (in_mac_bytes),
    .in_read_index        (in_read_index),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_entry_index      (out_entry_index),
    .out_multiple_flag    (out_multiple_flag),
    .out_entry_device_id  (out_entry_device_id),
    .out_entry_max_apdu   (out_entry_max_apdu),
    .out_entry_net        (out_entry_net),
    .out_entry_addr_len   (out_entry_addr_len),
    .out_entry_addr_bytes (out_entry_addr_bytes),
    .out_entry_mac_len    (out_entry_mac_len),
    .out_entry_mac_bytes  (out_entry_mac_bytes),
    .out_entry_count      (out_entry_count)
  );

endmodule

// ----- rtl/dat_checker.sv -----
// Port-level checker for the device address table, attached by bind.
// Depends on dat_pkg and on the ports of device_address_table_top.
module dat_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dat_pkg::STATUS_W-1:0]  out_status,
  input logic [dat_pkg::EIDX_W-1:0]    out_entry_index,
  input logic                          out_multiple_flag,
  input logic [dat_pkg::ID_W-1:0]      out_entry_device_id,
  input logic [dat_pkg::BYTES_W-1:0]   out_entry_addr_bytes,
  input logic [dat_pkg::LEN_W-1:0]     out_entry_mac_len,
  input logic [dat_pkg::ECNT_W-1:0]    out_entry_count
);

  // A pending result stays presented until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // One transaction in work at a time: ready falls right after acceptance.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in work");

  // The reported entry count never exceeds the table depth (checked for depths up to 127).
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TABLE_DEPTH > 127) || (int'(out_entry_count) <= TABLE_DEPTH))
    else $error("entry count above table depth");

  // An empty read carries no entry contents and no flag.
  a_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dat_pkg::STATUS_READ_EMPTY) |->
      !out_multiple_flag && (out_entry_device_id == '0) && (out_entry_mac_len == '0))
    else $error("empty read returned entry contents");

  // A dropped add reports index zero and carries no entry contents.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dat_pkg::STATUS_FULL) |->
      (out_entry_index == '0) && (out_entry_addr_bytes == '0))
    else $error("table-full result malformed");

endmodule

bind device_address_table_top dat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dat_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for device_address_table_top: directed and random
// add/read traffic checked against an in-bench copy of the device table.
// Depends on dat_pkg and the device_address_table_top RTL.
module tb_top;

  localparam int DEPTH = 64;
  localparam int LIMIT = 500000;

  typedef struct packed {
    dat_pkg::op_t                op;
    logic [dat_pkg::ID_W-1:0]    id;
    logic [dat_pkg::APDU_W-1:0]  apdu;
    logic [dat_pkg::NET_W-1:0]   net;
    logic [dat_pkg::LEN_W-1:0]   alen;
    logic [dat_pkg::BYTES_W-1:0] addr;
    logic [dat_pkg::LEN_W-1:0]   mlen;
    logic [dat_pkg::BYTES_W-1:0] mac;
    logic [dat_pkg::RIDX_W-1:0]  ridx;
  } dev_req_t;

  typedef struct packed {
    dat_pkg::status_t            status;
    logic [dat_pkg::EIDX_W-1:0]  idx;
    logic                        multi;
    logic [dat_pkg::ID_W-1:0]    id;
    logic [dat_pkg::APDU_W-1:0]  apdu;
    logic [dat_pkg::NET_W-1:0]   net;
    logic [dat_pkg::LEN_W-1:0]   alen;
    logic [dat_pkg::BYTES_W-1:0] addr;
    logic [dat_pkg::LEN_W-1:0]   mlen;
    logic [dat_pkg::BYTES_W-1:0] mac;
    logic [dat_pkg::ECNT_W-1:0]  count;
  } dev_reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_operation;
  logic [dat_pkg::ID_W-1:0]     in_device_id;
  logic [dat_pkg::APDU_W-1:0]   in_max_apdu;
  logic [dat_pkg::NET_W-1:0]    in_net_number;
  logic [dat_pkg::LEN_W-1:0]    in_addr_len;
  logic [dat_pkg::BYTES_W-1:0]  in_addr_bytes;
  logic [dat_pkg::LEN_W-1:0]    in_mac_len;
  logic [dat_pkg::BYTES_W-1:0]  in_mac_bytes;
  logic [dat_pkg::RIDX_W-1:0]   in_read_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [dat_pkg::STATUS_W-1:0] out_status;
  logic [dat_pkg::EIDX_W-1:0]   out_entry_index;
  logic                         out_multiple_flag;
  logic [dat_pkg::ID_W-1:0]     out_entry_device_id;
  logic [dat_pkg::APDU_W-1:0]   out_entry_max_apdu;
  logic [dat_pkg::NET_W-1:0]    out_entry_net;
  logic [dat_pkg::LEN_W-1:0]    out_entry_addr_len;
  logic [dat_pkg::BYTES_W-1:0]  out_entry_addr_bytes;
  logic [dat_pkg::LEN_W-1:0]    out_entry_mac_len;
  logic [dat_pkg::BYTES_W-1:0]  out_entry_mac_bytes;
  logic [dat_pkg::ECNT_W-1:0]   out_entry_count;

  // Bench copy of the device table.
  logic [dat_pkg::ID_W-1:0]    tbl_id   [DEPTH];
  logic [dat_pkg::APDU_W-1:0]  tbl_apdu [DEPTH];
  logic [dat_pkg::NET_W-1:0]   tbl_net  [DEPTH];
  logic [dat_pkg::LEN_W-1:0]   tbl_alen [DEPTH];
  logic [dat_pkg::BYTES_W-1:0] tbl_addr [DEPTH];
  logic [dat_pkg::LEN_W-1:0]   tbl_mlen [DEPTH];
  logic [dat_pkg::BYTES_W-1:0] tbl_mac  [DEPTH];
  logic                        tbl_multi[DEPTH];
  int                          tbl_count = 0;

  dev_reply_t reply_queue[$];
  dev_reply_t want;
  dev_req_t   seen;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         hold_request = 0;
  logic       sender_gaps = 1'b0;
  logic       receiver_stalls = 1'b0;

  device_address_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_device_id        (in_device_id),
    .in_max_apdu         (in_max_apdu),
    .in_net_number       (in_net_number),
    .in_addr_len         (in_addr_len),
    .in_addr_bytes       (in_addr_bytes),
    .in_mac_len          (in_mac_len),
    .in_mac_bytes        (in_mac_bytes),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_multiple_flag   (out_multiple_flag),
    .out_entry_device_id (out_entry_device_id),
    .out_entry_max_apdu  (out_entry_max_apdu),
    .out_entry_net       (out_entry_net),
    .out_entry_addr_len  (out_entry_addr_len),
    .out_entry_addr_bytes(out_entry_addr_bytes),
    .out_entry_mac_len   (out_entry_mac_len),
    .out_entry_mac_bytes (out_entry_mac_bytes),
    .out_entry_count     (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes that take part in the address comparison; lengths above the
  // compared byte count still compare only that many bytes.
  function automatic logic [dat_pkg::BYTES_W-1:0] compared_bytes(
      input logic [dat_pkg::LEN_W-1:0] len);
    int n;
    n = (int'(len) > dat_pkg::ADDR_BYTES) ? dat_pkg::ADDR_BYTES : int'(len);
    if (n >= dat_pkg::BYTES_W / 8) begin
      return '1;
    end
    return (dat_pkg::BYTES_W'(1) << (8 * n)) - dat_pkg::BYTES_W'(1);
  endfunction

  // Applies one add or read to the bench table and returns its reply.
  function automatic dev_reply_t table_access(input dev_req_t r);
    dev_reply_t rep;
    logic       found;
    int         hit;
    logic [dat_pkg::BYTES_W-1:0] keep;
    rep = '0;
    found = 1'b0;
    hit = 0;
    keep = compared_bytes(r.alen);
    if (r.op == dat_pkg::OP_READ) begin
      rep.idx = r.ridx;
      if (int'(r.ridx) < tbl_count) begin
        rep.status = dat_pkg::STATUS_READ_OK;
        rep.multi  = tbl_multi[r.ridx];
        rep.id     = tbl_id[r.ridx];
        rep.apdu   = tbl_apdu[r.ridx];
        rep.net    = tbl_net[r.ridx];
        rep.alen   = tbl_alen[r.ridx];
        rep.addr   = tbl_addr[r.ridx];
        rep.mlen   = tbl_mlen[r.ridx];
        rep.mac    = tbl_mac[r.ridx];
      end else begin
        rep.status = dat_pkg::STATUS_READ_EMPTY;
      end
    end else begin
      // Scan in index order; entries with the same id but another address
      // are marked until an equal entry ends the scan.
      for (int i = 0; i < tbl_count && !found; i++) begin
        if (tbl_id[i] == r.id) begin
          if (tbl_net[i] == r.net && tbl_alen[i] == r.alen &&
              ((tbl_addr[i] ^ r.addr) & keep) == '0) begin
            found = 1'b1;
            hit = i;
          end else begin
            rep.multi = 1'b1;
            tbl_multi[i] = 1'b1;
          end
        end
      end
      if (found) begin
        rep.status = dat_pkg::STATUS_PRESENT;
        rep.idx    = dat_pkg::EIDX_W'(hit);
        rep.multi  = tbl_multi[hit];
      end else if (tbl_count >= DEPTH) begin
        rep.status = dat_pkg::STATUS_FULL;
        rep.idx    = '0;
      end else begin
        rep.status          = dat_pkg::STATUS_ADDED;
        rep.idx             = dat_pkg::EIDX_W'(tbl_count);
        tbl_id[tbl_count]   = r.id;
        tbl_apdu[tbl_count] = r.apdu;
        tbl_net[tbl_count]  = r.net;
        tbl_alen[tbl_count] = r.alen;
        tbl_addr[tbl_count] = r.addr;
        tbl_mlen[tbl_count] = r.mlen;
        tbl_mac[tbl_count]  = r.mac;
        tbl_multi[tbl_count] = rep.multi;
        tbl_count++;
      end
    end
    rep.count = dat_pkg::ECNT_W'(tbl_count);
    return rep;
  endfunction

  function automatic dev_req_t make_add(input logic [dat_pkg::ID_W-1:0] id,
                                        input logic [dat_pkg::APDU_W-1:0] apdu,
                                        input logic [dat_pkg::NET_W-1:0] net,
                                        input logic [dat_pkg::LEN_W-1:0] alen,
                                        input logic [dat_pkg::BYTES_W-1:0] addr,
                                        input logic [dat_pkg::LEN_W-1:0] mlen,
                                        input logic [dat_pkg::BYTES_W-1:0] mac);
    dev_req_t r;
    r      = '0;
    r.op   = dat_pkg::OP_ADD;
    r.id   = id;
    r.apdu = apdu;
    r.net  = net;
    r.alen = alen;
    r.addr = addr;
    r.mlen = mlen;
    r.mac  = mac;
    return r;
  endfunction

  function automatic dev_req_t make_read(input logic [dat_pkg::RIDX_W-1:0] ridx);
    dev_req_t r;
    r      = '0;
    r.op   = dat_pkg::OP_READ;
    r.ridx = ridx;
    return r;
  endfunction

  // Random traffic that mostly revisits known devices: reads, repeats of stored
  // addresses, the same id at a slightly changed address, and new devices.
  function automatic dev_req_t random_request();
    dev_req_t r;
    int pick;
    int k;
    int nbytes;
    logic [dat_pkg::BYTES_W-1:0] keep;
    r.op   = dat_pkg::OP_ADD;
    r.id   = dat_pkg::ID_W'($urandom);
    r.apdu = dat_pkg::APDU_W'($urandom);
    r.net  = dat_pkg::NET_W'($urandom);
    r.alen = dat_pkg::LEN_W'($urandom);
    r.addr = dat_pkg::BYTES_W'({$urandom, $urandom});
    r.mlen = dat_pkg::LEN_W'($urandom);
    r.mac  = dat_pkg::BYTES_W'({$urandom, $urandom});
    r.ridx = dat_pkg::RIDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.op = dat_pkg::OP_READ;
      if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
        r.ridx = dat_pkg::RIDX_W'($urandom_range(0, tbl_count - 1));
      end
    end else if (tbl_count > 0 && pick < 88) begin
      k = $urandom_range(0, tbl_count - 1);
      r.id   = tbl_id[k];
      r.net  = tbl_net[k];
      r.alen = tbl_alen[k];
      if (pick < 76) begin
        // Equal address; bytes past the compared length are free.
        keep   = compared_bytes(r.alen);
        r.addr = (tbl_addr[k] & keep) | (r.addr & ~keep);
      end else begin
        r.addr = tbl_addr[k];
        case ($urandom_range(0, 2))
          0: r.net = r.net ^ dat_pkg::NET_W'($urandom_range(1, 65535));
          1: r.alen = r.alen ^ dat_pkg::LEN_W'($urandom_range(1, 7));
          default: begin
            nbytes = (int'(r.alen) > dat_pkg::ADDR_BYTES) ? dat_pkg::ADDR_BYTES
                                                           : int'(r.alen);
            if (nbytes == 0) begin
              r.alen = dat_pkg::LEN_W'($urandom_range(1, 7));
            end else begin
              r.addr = r.addr ^ (dat_pkg::BYTES_W'(1) << $urandom_range(0, nbytes * 8 - 1));
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  // Offers one transaction. Entered at a falling edge; returns at the
  // falling edge after acceptance with valid still high.
  task automatic send_request(input dev_req_t r);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_operation  = r.op;
    in_device_id  = r.id;
    in_max_apdu   = r.apdu;
    in_net_number = r.net;
    in_addr_len   = r.alen;
    in_addr_bytes = r.addr;
    in_mac_len    = r.mlen;
    in_mac_bytes  = r.mac;
    in_read_index = r.ridx;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted reply has come back.
  task automatic wait_replies_drained();
    in_valid = 1'b0;
    while (reply_queue.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(input string name, input logic [dat_pkg::BYTES_W-1:0] exp_val,
                              input logic [dat_pkg::BYTES_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Result checking first, then prediction of the newly accepted transaction,
  // so the order within one edge is fixed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reply_queue.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transaction with no prediction pending, status %0d",
                 $time, out_status);
      end else begin
        want = reply_queue.pop_front();
        report_field("status", want.status, out_status);
        report_field("entry_index", want.idx, out_entry_index);
        report_field("multiple_flag", want.multi, out_multiple_flag);
        report_field("entry_device_id", want.id, out_entry_device_id);
        report_field("entry_max_apdu", want.apdu, out_entry_max_apdu);
        report_field("entry_net", want.net, out_entry_net);
        report_field("entry_addr_len", want.alen, out_entry_addr_len);
        report_field("entry_addr_bytes", want.addr, out_entry_addr_bytes);
        report_field("entry_mac_len", want.mlen, out_entry_mac_len);
        report_field("entry_mac_bytes", want.mac, out_entry_mac_bytes);
        report_field("entry_count", want.count, out_entry_count);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      seen.op   = dat_pkg::op_t'(in_operation);
      seen.id   = in_device_id;
      seen.apdu = in_max_apdu;
      seen.net  = in_net_number;
      seen.alen = in_addr_len;
      seen.addr = in_addr_bytes;
      seen.mlen = in_mac_len;
      seen.mac  = in_mac_bytes;
      seen.ridx = in_read_index;
      reply_queue.push_back(table_access(seen));
    end
  end

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  initial begin
    int k;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        k = hold_request;
        hold_request = 0;
        while (k > 1) begin
          @(negedge clk);
          k--;
        end
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Extremes of every field, both operations and the address corner cases.
  task automatic test_directed();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    send_request(make_read(6'd0));
    send_request(make_add('0, '0, '0, 3'd0, '1, 3'd0, '0));
    // Zero-length address matches whatever the bytes hold.
    send_request(make_add('0, '1, '0, 3'd0, '0, 3'd7, '1));
    send_request(make_add('1, '1, '1, 3'd6, '1, 3'd6, '1));
    // Same id on another network marks both entries.
    send_request(make_add('1, '1, 16'hFFFE, 3'd6, '1, 3'd6, '1));
    // MAC and APDU are not compared.
    send_request(make_add('1, '0, '1, 3'd6, '1, 3'd0, '0));
    // Length above the compared byte count still differs by length.
    send_request(make_add('1, '1, '1, 3'd7, '1, 3'd7, '1));
    send_request(make_add('1, 16'h1234, '1, 3'd7, '1, 3'd2, 48'h5A));
    send_request(make_add('1, '1, '1, 3'd5, 48'h00FF_FFFF_FFFF, 3'd1, '1));
    // One differing byte within the length, then a match found part way.
    send_request(make_add(22'd5, 16'h1234, 16'h0100, 3'd2, 48'h1234, 3'd1, 48'hA1));
    send_request(make_add(22'd5, 16'h4321, 16'h0100, 3'd2, 48'h1334, 3'd1, 48'hA2));
    send_request(make_add(22'd5, 16'h0001, 16'h0100, 3'd2, 48'hFF_1234, 3'd3, 48'hA3));
    send_request(make_add(22'd5, 16'h0002, 16'h0100, 3'd2, 48'h1334, 3'd4, 48'hA4));
    send_request(make_add(22'h2AAAAA, 16'h5555, 16'hAAAA, 3'd4, 48'h5555_5555_5555,
                          3'd5, 48'hAAAA_AAAA_AAAA));
    send_request(make_add(22'h155555, 16'hAAAA, 16'h5555, 3'd3, 48'hAAAA_AAAA_AAAA,
                          3'd2, 48'h5555_5555_5555));
    send_request(make_read(6'd0));
    send_request(make_read(6'd1));
    send_request(make_read(6'd2));
    send_request(make_read(6'd3));
    send_request(make_read(6'd4));
    send_request(make_read(6'd6));
    send_request(make_read(6'd8));
    send_request(make_read(6'd9));
    send_request(make_read(6'd63));
  endtask

  // Mixed random traffic; idling on either side changes every 50 transactions.
  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        sender_gaps = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
    end
  endtask

  // Fills the table and checks adds that find no room.
  task automatic test_table_full();
    int k;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    while (tbl_count < DEPTH) begin
      send_request(make_add(dat_pkg::ID_W'($urandom), dat_pkg::APDU_W'($urandom),
                            dat_pkg::NET_W'($urandom), dat_pkg::LEN_W'($urandom),
                            dat_pkg::BYTES_W'({$urandom, $urandom}),
                            dat_pkg::LEN_W'($urandom),
                            dat_pkg::BYTES_W'({$urandom, $urandom})));
    end
    k = $urandom_range(0, DEPTH - 1);
    send_request(make_add(dat_pkg::ID_W'($urandom), '1, '1, 3'd6, '1, 3'd6, '1));
    // Known id at a new address: dropped, but the flags set by the scan stay.
    send_request(make_add(tbl_id[k], '0, tbl_net[k] ^ 16'h0001, tbl_alen[k],
                          tbl_addr[k], '0, '0));
    send_request(make_add(tbl_id[k], '1, tbl_net[k], tbl_alen[k], tbl_addr[k], '1, '1));
    send_request(make_read(dat_pkg::RIDX_W'(k)));
    send_request(make_read(6'd63));
    send_request(make_read(6'd0));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_request = 300;
    repeat (12) send_request(random_request());
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_quiet_tail(input int n);
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    repeat (n) send_request(random_request());
  endtask

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = 1'b0;
    in_device_id  = '0;
    in_max_apdu   = '0;
    in_net_number = '0;
    in_addr_len   = '0;
    in_addr_bytes = '0;
    in_mac_len    = '0;
    in_mac_bytes  = '0;
    in_read_index = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_replies_drained();
    test_random_traffic(400);
    wait_replies_drained();
    test_table_full();
    wait_replies_drained();
    test_backpressure();
    wait_replies_drained();
    test_quiet_tail(200);
    wait_replies_drained();

    // Let any stray result transaction show up before the verdict.
    repeat (100) @(posedge clk);
    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
